// ----- hdl/lcdfs_pkg.sv -----
// Shared types and constants for the LCD frame store refresh unit.
// No dependencies; imported by the refresh sequencer and the top level.
`default_nettype none

package lcdfs_pkg;

  // Default geometry of the panel
  localparam int unsigned COLUMNS_DEF = 128;
  localparam int unsigned PAGES_DEF   = 8;

  // Refresh header: page address, column high nibble, column low nibble
  localparam logic [7:0]  CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0]  CMD_COL_HIGH  = 8'h10;
  localparam logic [7:0]  CMD_COL_LOW   = 8'h00;
  localparam int unsigned HEADER_LEN    = 3;

  // Pixel bit for row 0 within a page byte
  localparam logic [7:0]  PIXEL_MSB     = 8'h80;

  // Request modes
  typedef enum logic [1:0] {
    MODE_PIXEL   = 2'd0,
    MODE_CLEAR   = 2'd1,
    MODE_REFRESH = 2'd2
  } mode_e;

  // Description of the next refresh byte, handed from sequencer to top level
  typedef struct packed {
    logic       is_data;
    logic       last;
    logic [7:0] cmd;
  } refresh_info_t;

endpackage

`default_nettype wire

// ----- hdl/lcdfs_ram.sv -----
// Single-port synchronous frame store memory with registered read data.
// Depends on nothing; used by the top level.
`default_nettype none

module lcdfs_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [7:0]    wdata_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];

  // Write or read one byte per cycle; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/lcdfs_refresh_seq.sv -----
// Refresh position counters: page and step within the page, and the
// description and store address of the next refresh byte. Uses lcdfs_pkg.
`default_nettype none

module lcdfs_refresh_seq #(
  parameter int unsigned COLUMNS = lcdfs_pkg::COLUMNS_DEF,
  parameter int unsigned PAGES   = lcdfs_pkg::PAGES_DEF,
  parameter int unsigned AW      = $clog2(COLUMNS * PAGES)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     advance_i,
  output lcdfs_pkg::refresh_info_t      info_o,
  output logic [AW-1:0]                 addr_o
);

  import lcdfs_pkg::*;

  localparam int unsigned SW = $clog2(COLUMNS + HEADER_LEN);
  localparam int unsigned PW = (PAGES > 1) ? $clog2(PAGES) : 1;

  localparam logic [SW-1:0] StepLast = SW'(COLUMNS + HEADER_LEN - 1);
  localparam logic [SW-1:0] StepHdr  = SW'(HEADER_LEN);
  localparam logic [PW-1:0] PageLast = PW'(PAGES - 1);

  logic [PW-1:0] page_q, page_d;
  logic [SW-1:0] step_q, step_d;
  logic [SW-1:0] col;

  // Advance one byte through the page; wrap page after the last column
  always_comb begin
    page_d = page_q;
    step_d = step_q;
    if (advance_i) begin
      if (step_q == StepLast) begin
        step_d = '0;
        page_d = (page_q == PageLast) ? '0 : page_q + PW'(1);
      end else begin
        step_d = step_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= '0;
      step_q <= '0;
    end else begin
      page_q <= page_d;
      step_q <= step_d;
    end
  end

  // Decode the current byte: header commands first, then column data
  always_comb begin
    info_o.is_data = (step_q >= StepHdr);
    info_o.last    = info_o.is_data && (page_q == PageLast) && (step_q == StepLast);
    case (step_q)
      SW'(0):  info_o.cmd = CMD_PAGE_BASE + 8'(page_q);
      SW'(1):  info_o.cmd = CMD_COL_HIGH;
      default: info_o.cmd = CMD_COL_LOW;
    endcase
  end

  assign col    = step_q - StepHdr;
  assign addr_o = AW'(page_q) * AW'(COLUMNS) + AW'(col);

endmodule

`default_nettype wire

// ----- hdl/lcd_frame_store_refresh_unit.sv -----
// Top level of the LCD frame store refresh unit: request decode, store
// sweep, pixel read-modify-write. Uses lcdfs_pkg, lcdfs_ram, lcdfs_refresh_seq.
//
//   port group  direction  handshake                 payload
//   request     in         start / busy              mode_i x_coord_i y_coord_i pixel_on_i
//   result      out        out_strobe_o (1 cycle)    out_byte_o is_data_o frame_last_o
//
// A request is taken at a clock edge with start high and busy low.
// Pixel draw: store read at the request, then write back of the modified byte.
// Refresh byte: result strobes in the cycle after the request; a new request
// may be taken in that same cycle. Ignored or out-of-range commands never raise busy.
// Clear: the request cycle and then one store byte written per cycle with busy
// high.
// After reset the same sweep runs with busy high.
// The result side has no stall; each result is shown for exactly one cycle.
`default_nettype none

module lcd_frame_store_refresh_unit #(
  parameter int unsigned COLUMNS = lcdfs_pkg::COLUMNS_DEF,
  parameter int unsigned PAGES   = lcdfs_pkg::PAGES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] mode_i,
  input  wire logic [7:0] x_coord_i,
  input  wire logic [7:0] y_coord_i,
  input  wire logic       pixel_on_i,
  output logic            out_strobe_o,
  output logic [7:0]      out_byte_o,
  output logic            is_data_o,
  output logic            frame_last_o
);

  import lcdfs_pkg::*;

  localparam int unsigned DEPTH = COLUMNS * PAGES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam logic [AW-1:0] ClrLast = AW'(DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_PIXEL   = 4'b0010,
    ST_REFRESH = 4'b0100,
    ST_CLEAR   = 4'b1000
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          accept;
  logic          pix_in_range;
  logic [PW-1:0] pix_page;
  logic [AW-1:0] pix_addr;
  logic [AW-1:0] pix_addr_q;
  logic [7:0]    pix_mask_q;
  logic          pix_on_q;
  refresh_info_t info, info_q;
  logic [AW-1:0] seq_addr;
  logic          seq_advance;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata, mem_rdata;

  assign busy   = (state_q == ST_PIXEL) || (state_q == ST_CLEAR);
  assign accept = start && !busy;

  // Decode pixel coordinates into store address
  assign pix_in_range = ({1'b0, x_coord_i} < 9'(COLUMNS)) && ({1'b0, y_coord_i} < 9'(PAGES * 8));
  assign pix_page     = PW'(PAGES - 1) - PW'(y_coord_i[7:3]);
  assign pix_addr     = AW'(pix_page) * AW'(COLUMNS) + AW'(x_coord_i);

  assign seq_advance = accept && (mode_i == MODE_REFRESH);

  lcdfs_refresh_seq #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES),
    .AW      (AW)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (seq_advance),
    .info_o    (info),
    .addr_o    (seq_addr)
  );

  // Next state and clear counter
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + AW'(1);
        if (clr_q == ClrLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_PIXEL: begin
        state_d = ST_IDLE;
      end
      ST_IDLE, ST_REFRESH: begin
        state_d = ST_IDLE;
        if (accept) begin
          case (mode_i)
            MODE_PIXEL:   state_d = pix_in_range ? ST_PIXEL : ST_IDLE;
            MODE_CLEAR: begin
              state_d = ST_CLEAR;
              clr_d   = '0;
            end
            MODE_REFRESH: state_d = ST_REFRESH;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  // Hold the request details for the following cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pix_addr_q <= pix_addr;
      pix_mask_q <= PIXEL_MSB >> y_coord_i[2:0];
      pix_on_q   <= pixel_on_i;
      info_q     <= info;
    end
  end

  // Store port: sweep, pixel write-back, or read at request
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = pix_addr;
    mem_wdata = '0;
    if (state_q == ST_CLEAR) begin
      mem_we   = 1'b1;
      mem_addr = clr_q;
    end else if (state_q == ST_PIXEL) begin
      mem_we    = 1'b1;
      mem_addr  = pix_addr_q;
      mem_wdata = pix_on_q ? (mem_rdata | pix_mask_q) : (mem_rdata & ~pix_mask_q);
    end else if (accept) begin
      if (mode_i == MODE_PIXEL) begin
        mem_re = pix_in_range;
      end else if (mode_i == MODE_REFRESH) begin
        mem_re   = info.is_data;
        mem_addr = seq_addr;
      end
    end
  end

  lcdfs_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Drive the result during the cycle after a refresh request
  assign out_strobe_o = (state_q == ST_REFRESH);
  assign out_byte_o   = info_q.is_data ? mem_rdata : info_q.cmd;
  assign is_data_o    = info_q.is_data;
  assign frame_last_o = info_q.last;

  // A result appears only right after a refresh request
  a_strobe_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> $past(accept && (mode_i == MODE_REFRESH)))
    else $error("result strobe without refresh request");

  // Write-back only right after an in-range pixel request
  a_pixel_follows_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIXEL) |-> $past(accept && (mode_i == MODE_PIXEL) && pix_in_range))
    else $error("pixel write-back without pixel request");

  // The single store port never reads and writes in one cycle
  a_port_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("store read and write collide");

  // The sweep runs to the last entry before going idle
  a_clear_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CLEAR) && (clr_q != ClrLast)) |=> (state_q == ST_CLEAR))
    else $error("clear sweep ended early");

  // Frame end is marked only on a data byte
  a_last_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && frame_last_o) |-> is_data_o)
    else $error("frame end on a command byte");

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for lcd_frame_store_refresh_unit: draw, clear and refresh
// requests are checked against a shadow frame store and refresh position.
// Depends on lcdfs_pkg and the block's RTL.

module tb;
  import lcdfs_pkg::*;

  localparam int unsigned COLS            = COLUMNS_DEF;
  localparam int unsigned PGS             = PAGES_DEF;
  localparam int unsigned ROWS            = PGS * 8;
  localparam int unsigned SWEEP_CYCLES    = COLS * PGS;
  localparam int unsigned RANDOM_REQUESTS = 1525;
  localparam int unsigned MAX_GAP         = 3;
  localparam logic [1:0]  MODE_UNUSED     = 2'd3;

  // Positions of the header commands within one page of the refresh stream
  localparam int unsigned STEP_PAGE_CMD   = 0;
  localparam int unsigned STEP_COL_HIGH   = 1;

  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        on;
    int unsigned gap;
    bit          drain;
  } request_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_last;
  } panel_byte_t;

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       start      = 1'b0;
  logic [1:0] mode_i     = MODE_PIXEL;
  logic [7:0] x_coord_i  = '0;
  logic [7:0] y_coord_i  = '0;
  logic       pixel_on_i = 1'b0;
  logic       busy;
  logic       out_strobe_o;
  logic [7:0] out_byte_o;
  logic       is_data_o;
  logic       frame_last_o;

  // Shadow of the block's store and refresh position
  logic [7:0]             shadow_store [PGS][COLS];
  logic [$clog2(PGS)-1:0] scan_page = '0;
  logic [7:0]             scan_step = '0;

  request_t    pending_q [$];
  panel_byte_t panel_bytes_q [$];
  request_t    active_req;
  int unsigned gap_left          = 0;
  int unsigned requests_total    = 0;
  int unsigned requests_taken    = 0;
  int unsigned bytes_predicted   = 0;
  int unsigned bytes_seen        = 0;
  int unsigned mismatches        = 0;
  longint      cycle_count       = 0;
  longint      cycle_limit       = 64'd50_000_000;

  lcd_frame_store_refresh_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .mode_i      (mode_i),
    .x_coord_i   (x_coord_i),
    .y_coord_i   (y_coord_i),
    .pixel_on_i  (pixel_on_i),
    .out_strobe_o(out_strobe_o),
    .out_byte_o  (out_byte_o),
    .is_data_o   (is_data_o),
    .frame_last_o(frame_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Append one request; a gap of idle cycles may follow it unless quiet
  task automatic queue_request(input logic [1:0] mode, input logic [7:0] x,
                               input logic [7:0] y, input logic on,
                               input bit drain, input bit quiet);
    request_t req;
    req.mode  = mode;
    req.x     = x;
    req.y     = y;
    req.on    = on;
    req.drain = drain;
    req.gap   = (!quiet && $urandom_range(0, 99) < 17) ? $urandom_range(1, MAX_GAP) : 0;
    pending_q.push_back(req);
    requests_total++;
  endtask

  // Apply one accepted request to the shadow store; queue the refresh byte it yields
  task automatic apply_request(input request_t req);
    panel_byte_t nb;
    int unsigned col;
    int unsigned pg;
    case (req.mode)
      MODE_PIXEL: begin
        if (req.x < COLS && req.y < ROWS) begin
          pg = PGS - 1 - (req.y >> 3);
          if (req.on) shadow_store[pg][req.x] |= PIXEL_MSB >> req.y[2:0];
          else shadow_store[pg][req.x] &= ~(PIXEL_MSB >> req.y[2:0]);
        end
      end
      MODE_CLEAR: begin
        foreach (shadow_store[p, c]) shadow_store[p][c] = '0;
      end
      MODE_REFRESH: begin
        nb.is_data    = (scan_step >= HEADER_LEN);
        nb.frame_last = 1'b0;
        if (scan_step == STEP_PAGE_CMD) begin
          nb.out_byte = CMD_PAGE_BASE + 8'(scan_page);
        end else if (scan_step == STEP_COL_HIGH) begin
          nb.out_byte = CMD_COL_HIGH;
        end else if (scan_step < HEADER_LEN) begin
          nb.out_byte = CMD_COL_LOW;
        end else begin
          col           = scan_step - HEADER_LEN;
          nb.out_byte   = shadow_store[scan_page][col];
          nb.frame_last = (scan_page == PGS - 1) && (col == COLS - 1);
        end
        panel_bytes_q.push_back(nb);
        bytes_predicted++;
        // advance to the next byte, wrapping page and frame
        if (scan_step == HEADER_LEN + COLS - 1) begin
          scan_step = '0;
          scan_page = (scan_page == PGS - 1) ? '0 : scan_page + 1'b1;
        end else begin
          scan_step++;
        end
      end
      default: ;
    endcase
  endtask

  // Request driver: hold while busy, then present the next pending request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start    <= 1'b0;
      gap_left = 0;
    end else if (!(start && busy)) begin
      if (start) begin
        apply_request(active_req);
        requests_taken++;
        gap_left = active_req.gap;
      end
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (pending_q.size() > 0 &&
                   (!pending_q[0].drain || bytes_seen == bytes_predicted)) begin
        active_req = pending_q.pop_front();
        start      <= 1'b1;
        mode_i     <= active_req.mode;
        x_coord_i  <= active_req.x;
        y_coord_i  <= active_req.y;
        pixel_on_i <= active_req.on;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Result monitor: compare each strobed byte with the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    panel_byte_t want;
    if (!rst_ni) begin
      bytes_seen <= 0;
    end else if (out_strobe_o) begin
      if (panel_bytes_q.size() == 0) begin
        $error("unexpected refresh byte %0h (is_data %0b)", out_byte_o, is_data_o);
        mismatches++;
      end else begin
        want = panel_bytes_q.pop_front();
        if (out_byte_o !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_byte_o);
          mismatches++;
        end
        if (is_data_o !== want.is_data) begin
          $error("is_data: expected %0b, got %0b", want.is_data, is_data_o);
          mismatches++;
        end
        if (frame_last_o !== want.frame_last) begin
          $error("frame_last: expected %0b, got %0b", want.frame_last, frame_last_o);
          mismatches++;
        end
      end
      bytes_seen <= bytes_seen + 1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned pick;
    logic [7:0]  rx;
    logic [7:0]  ry;
    logic        ron;
    bit          quiet;
    longint      worst;

    foreach (shadow_store[p, c]) shadow_store[p][c] = '0;

    // Header bytes straight out of reset
    queue_request(MODE_REFRESH, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
    queue_request(MODE_REFRESH, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0);
    queue_request(MODE_REFRESH, 8'd128, 8'd64, 1'b0, 1'b0, 1'b0);
    // Pixels in the first page, set and cleared again
    queue_request(MODE_PIXEL, 8'd0, 8'd63, 1'b1, 1'b0, 1'b0);
    queue_request(MODE_PIXEL, 8'd1, 8'd56, 1'b1, 1'b0, 1'b0);
    queue_request(MODE_PIXEL, 8'd2, 8'd60, 1'b1, 1'b0, 1'b0);
    queue_request(MODE_PIXEL, 8'd2, 8'd60, 1'b0, 1'b0, 1'b0);
    queue_request(MODE_PIXEL, 8'd2, 8'd57, 1'b1, 1'b0, 1'b0);
    // Coordinates off the panel leave the store alone
    queue_request(MODE_PIXEL, 8'd128, 8'd63, 1'b1, 1'b0, 1'b0);
    queue_request(MODE_PIXEL, 8'd0, 8'd64, 1'b1, 1'b0, 1'b0);
    queue_request(MODE_PIXEL, 8'd255, 8'd255, 1'b1, 1'b0, 1'b0);
    // Corners of the last page
    queue_request(MODE_PIXEL, 8'd127, 8'd0, 1'b1, 1'b0, 1'b0);
    queue_request(MODE_PIXEL, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0);
    // Unused mode does nothing
    queue_request(MODE_UNUSED, 8'd3, 8'd60, 1'b1, 1'b0, 1'b0);
    queue_request(MODE_REFRESH, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
    queue_request(MODE_REFRESH, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
    queue_request(MODE_REFRESH, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0);
    // Clear keeps the refresh position
    queue_request(MODE_CLEAR, 8'd7, 8'd9, 1'b1, 1'b1, 1'b0);
    queue_request(MODE_REFRESH, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1);
    queue_request(MODE_PIXEL, 8'd4, 8'd63, 1'b1, 1'b0, 1'b1);
    queue_request(MODE_REFRESH, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1);
    queue_request(MODE_PIXEL, 8'd127, 8'd63, 1'b1, 1'b0, 1'b1);
    queue_request(MODE_REFRESH, 8'd0, 8'd0, 1'b0, 1'b0, 1'b1);

    // Mostly refresh traffic with pixels in between, so whole frames get scanned
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      pick  = $urandom_range(0, 999);
      quiet = (i >= 500 && i < 800);
      rx    = 8'($urandom_range(0, 255));
      ry    = 8'($urandom_range(0, 255));
      ron   = 1'($urandom_range(0, 1));
      if (pick < 720) begin
        queue_request(MODE_REFRESH, rx, ry, ron, 1'b0, quiet);
      end else if (pick < 900) begin
        queue_request(MODE_PIXEL, 8'($urandom_range(0, COLS - 1)),
                      8'($urandom_range(0, ROWS - 1)), ron, 1'b0, quiet);
      end else if (pick < 975) begin
        queue_request(MODE_PIXEL, rx, ry, ron, 1'b0, quiet);
      end else if (pick < 985) begin
        queue_request(MODE_UNUSED, rx, ry, ron, 1'b0, quiet);
      end else if (pick < 990) begin
        queue_request(MODE_CLEAR, rx, ry, ron, 1'b0, quiet);
      end else begin
        queue_request(MODE_REFRESH, rx, ry, ron, 1'b1, quiet);
      end
    end

    // Bound the run from the slowest legal schedule of this stimulus
    worst = 2 * SWEEP_CYCLES + 64;
    foreach (pending_q[i]) begin
      worst += pending_q[i].gap + 3 + (pending_q[i].drain ? 2 : 0);
      if (pending_q[i].mode == MODE_CLEAR) worst += SWEEP_CYCLES;
    end
    cycle_limit = 4 * worst + 10000;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every request taken, every byte back, then let the block settle
    while (requests_taken != requests_total || bytes_seen != bytes_predicted)
      @(posedge clk_i);
    repeat (SWEEP_CYCLES + 16) @(posedge clk_i);

    if (panel_bytes_q.size() != 0)
      $error("%0d refresh bytes never arrived", panel_bytes_q.size());
    if (mismatches == 0 && panel_bytes_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
